### hdl/imufp_pkg.sv
// ----------------------------------------------------------------------------
// imufp_pkg
// shared types and constants of the imu frame parser with yaw filter
// ----------------------------------------------------------------------------
package imufp_pkg;

  localparam int FRAME_BYTES = 11;
  // bytes held in the window; the last frame byte is checked on arrival
  localparam int WIN_DEPTH   = FRAME_BYTES - 1;
  localparam int CNT_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] HEAD_BYTE  = 8'h55;
  localparam logic [7:0] KIND_ANGLE = 8'h53;
  localparam logic [7:0] KIND_RATE  = 8'h52;

  localparam logic [8:0] WEIGHT_ONE   = 9'd256;
  localparam logic [8:0] WEIGHT_RESET = 9'd230;

  // frame_kind codes on the result side
  localparam logic KIND_CODE_ANGLE = 1'b0;
  localparam logic KIND_CODE_RATE  = 1'b1;

  // register indexes of the configuration port
  localparam logic REG_WEIGHT = 1'b0;

  typedef struct packed {
    logic               hit;
    logic               kind;
    logic signed [15:0] raw_z;
  } frame_t;

endpackage

### hdl/imufp_window.sv
// ----------------------------------------------------------------------------
// imufp_window
// byte window, header and checksum test, z field extraction
// ----------------------------------------------------------------------------
module imufp_window (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [7:0]            rx_byte,
  output imufp_pkg::frame_t     frame
);

  logic [7:0]                  win_r [imufp_pkg::WIN_DEPTH];
  logic [imufp_pkg::CNT_W-1:0] cnt_r;
  logic [imufp_pkg::CNT_W-1:0] cnt_nxt;
  logic                        full;
  logic [7:0]                  sum;
  logic                        kind_ok;
  logic                        pass;

  assign full = (cnt_r == imufp_pkg::CNT_W'(imufp_pkg::WIN_DEPTH));

  // 8-bit checksum over the held bytes
  assign sum = ((win_r[0] + win_r[1]) + (win_r[2] + win_r[3]) + win_r[4])
             + ((win_r[5] + win_r[6]) + (win_r[7] + win_r[8]) + win_r[9]);

  assign kind_ok = (win_r[1] == imufp_pkg::KIND_ANGLE) ||
                   (win_r[1] == imufp_pkg::KIND_RATE);
  assign pass    = full && (win_r[0] == imufp_pkg::HEAD_BYTE) && kind_ok &&
                   (sum == rx_byte);

  assign frame.hit   = push && pass;
  assign frame.kind  = (win_r[1] == imufp_pkg::KIND_RATE) ? imufp_pkg::KIND_CODE_RATE
                                                          : imufp_pkg::KIND_CODE_ANGLE;
  assign frame.raw_z = $signed({win_r[7], win_r[6]});

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      if (!full) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (pass) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = imufp_pkg::CNT_W'(imufp_pkg::WIN_DEPTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // window bytes need no reset, only written entries are ever used
  always_ff @(posedge clk) begin
    if (push) begin
      if (!full) begin
        win_r[cnt_r] <= rx_byte;
      end else if (!pass) begin
        // drop the oldest byte, new byte becomes the last held one
        for (int i = 0; i < imufp_pkg::WIN_DEPTH - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[imufp_pkg::WIN_DEPTH-1] <= rx_byte;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= imufp_pkg::CNT_W'(imufp_pkg::WIN_DEPTH))
    else $error("window count out of range");

  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    frame.hit |=> cnt_r == '0)
    else $error("accepted frame did not empty the window");

  a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    push && full && !pass |=> cnt_r == imufp_pkg::CNT_W'(imufp_pkg::WIN_DEPTH))
    else $error("failed frame did not keep ten bytes");

  a_hit_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    frame.hit |-> full)
    else $error("frame hit without full window");

endmodule

### hdl/imufp_calc.sv
// ----------------------------------------------------------------------------
// imufp_calc
// yaw iir filter, blink toggle and rate scaling
// ----------------------------------------------------------------------------
module imufp_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  imufp_pkg::frame_t  frame,
  input  logic [8:0]         weight,
  output logic signed [23:0] yaw_out,
  output logic signed [15:0] rate_out,
  output logic               blink_out
);

  logic signed [23:0] yaw_r;
  logic               blink_r;
  logic               upd;
  logic [8:0]         w_eff;
  logic [8:0]         w_inv;
  logic signed [25:0] prod_new;
  logic signed [34:0] prod_old;
  logic signed [34:0] acc;
  logic signed [23:0] yaw_nxt;
  logic signed [22:0] r125;

  assign upd = frame.hit && (frame.kind == imufp_pkg::KIND_CODE_ANGLE);

  // weights above one count as one
  assign w_eff = weight[8] ? imufp_pkg::WEIGHT_ONE : weight;
  assign w_inv = imufp_pkg::WEIGHT_ONE - w_eff;

  assign prod_new = $signed({1'b0, w_eff}) * frame.raw_z;
  assign prod_old = $signed({1'b0, w_inv}) * yaw_r;
  assign acc      = $signed({prod_new, 8'h00}) + prod_old;
  // floor shift by 8 is a plain bit slice
  assign yaw_nxt  = acc[31:8];

  // raw*125 = raw*128 - raw*4 + raw, then floor divide by 128
  assign r125 = $signed({frame.raw_z, 7'b0}) - $signed({frame.raw_z, 2'b0}) + frame.raw_z;

  assign yaw_out   = upd ? yaw_nxt : yaw_r;
  assign blink_out = upd ? ~blink_r : blink_r;
  assign rate_out  = (frame.kind == imufp_pkg::KIND_CODE_RATE) ? r125[22:7] : 16'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r   <= '0;
      blink_r <= 1'b0;
    end else if (upd) begin
      yaw_r   <= yaw_nxt;
      blink_r <= ~blink_r;
    end
  end

endmodule

### hdl/imu_frame_parser_yaw_filter.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_yaw_filter
// parses 11-byte sum-checked imu frames and filters the yaw angle
// ----------------------------------------------------------------------------
// in channel: one received byte per item on in_tdata
// out channel: one item per accepted frame; frame kind on out_tuser
//   (0 angle, 1 rate), z value, filtered yaw, rate and blink on out_tdata
// cfg port: apb-style, register 0 at address 0 is the new sample weight
//   in 1/256 units (reset 230), values above 256 act as 256
// a byte is taken every cycle; the window test, checksum and filter step
//   all run in the cycle the byte is accepted, so the result item is on
//   out_tvalid in the cycle after the eleventh byte of a good frame
// a bad frame drops only its oldest byte, so the parser resyncs byte by byte
// reset empties the window, clears yaw and blink, and loads the weight
// when the receiver stalls, the result stays in the output register and
//   in_tready drops until it is taken; a result taken in the same cycle
//   lets a new byte in without a bubble
// ----------------------------------------------------------------------------
module imu_frame_parser_yaw_filter (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [15:0] raw_z, [39:16] yaw_filtered,
                                   // [55:40] rate_sixteenths, [56] blink
  output logic        out_tuser,   // [0] frame_kind
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  imufp_pkg::frame_t  frame;
  logic               push;
  logic [8:0]         weight_r;
  logic signed [23:0] yaw_val;
  logic signed [15:0] rate_val;
  logic               blink_val;
  logic               cfg_wr;

  logic               out_vld_r;
  logic               kind_r;
  logic signed [15:0] raw_r;
  logic signed [23:0] yaw_r;
  logic signed [15:0] rate_r;
  logic               blink_r;

  // accept while the output slot is empty or being emptied
  assign in_tready = !out_vld_r || out_tready;
  assign push      = in_tvalid && in_tready;

  imufp_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rx_byte (in_tdata),
    .frame   (frame)
  );

  imufp_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .weight    (weight_r),
    .yaw_out   (yaw_val),
    .rate_out  (rate_val),
    .blink_out (blink_val)
  );

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= imufp_pkg::WEIGHT_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == imufp_pkg::REG_WEIGHT)) begin
      weight_r <= cfg_pwdata[8:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == imufp_pkg::REG_WEIGHT) ? {23'b0, weight_r} : 32'b0;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push) begin
      out_vld_r <= frame.hit;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (frame.hit) begin
      kind_r  <= frame.kind;
      raw_r   <= frame.raw_z;
      yaw_r   <= yaw_val;
      rate_r  <= rate_val;
      blink_r <= blink_val;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {7'b0, blink_r, rate_r, yaw_r, raw_r};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |=> out_vld_r && $stable(out_tdata))
    else $error("result lost under stall");

  a_no_push_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |-> !push)
    else $error("byte accepted while result blocked");

  a_rate_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (kind_r == imufp_pkg::KIND_CODE_ANGLE) |-> rate_r == 16'sd0)
    else $error("rate field set on angle frame");

endmodule

### sim/imufp_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imufp_frame_checker
// watches the byte, result and register channels of the imu frame parser,
// rebuilds the frame window, yaw filter and blink bit on its own, and
// compares every result item field by field with the oldest predicted frame
// ----------------------------------------------------------------------------
module imufp_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          frames_pending
);

  typedef struct {
    logic               kind;
    logic signed [15:0] raw_z;
    logic signed [23:0] yaw;
    logic signed [15:0] rate;
    logic               blink;
  } frame_result_t;

  frame_result_t      frames_due[$];
  logic [7:0]         rx_window [imufp_pkg::FRAME_BYTES];
  int                 rx_fill;
  logic signed [23:0] yaw_now;
  logic               blink_now;
  logic [8:0]         weight_reg;

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // one received byte into the window; a good full window yields a frame
  task automatic take_rx_byte(input logic [7:0] b);
    logic [7:0]    sum;
    logic [8:0]    w;
    longint        wl;
    longint        acc;
    frame_result_t r;
    rx_window[rx_fill] = b;
    rx_fill++;
    if (rx_fill == imufp_pkg::FRAME_BYTES) begin
      sum = '0;
      for (int i = 0; i < imufp_pkg::FRAME_BYTES - 1; i++) sum = sum + rx_window[i];
      if (rx_window[0] != imufp_pkg::HEAD_BYTE ||
          (rx_window[1] != imufp_pkg::KIND_ANGLE && rx_window[1] != imufp_pkg::KIND_RATE) ||
          sum != rx_window[imufp_pkg::FRAME_BYTES-1]) begin
        // slide by one byte and keep hunting for a header
        for (int i = 0; i < imufp_pkg::FRAME_BYTES - 1; i++) rx_window[i] = rx_window[i+1];
        rx_fill = imufp_pkg::FRAME_BYTES - 1;
      end else begin
        r.raw_z = {rx_window[7], rx_window[6]};
        if (rx_window[1] == imufp_pkg::KIND_ANGLE) begin
          w   = (weight_reg > imufp_pkg::WEIGHT_ONE) ? imufp_pkg::WEIGHT_ONE : weight_reg;
          wl  = w;
          acc = wl * longint'(r.raw_z) * 256 + (256 - wl) * longint'(yaw_now);
          yaw_now   = 24'(acc >>> 8);
          blink_now = ~blink_now;
          r.kind    = imufp_pkg::KIND_CODE_ANGLE;
          r.rate    = '0;
        end else begin
          r.kind = imufp_pkg::KIND_CODE_RATE;
          r.rate = 16'((longint'(r.raw_z) * 125) >>> 7);
        end
        r.yaw   = yaw_now;
        r.blink = blink_now;
        rx_fill = 0;
        frames_due.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      rx_fill    = 0;
      yaw_now    = '0;
      blink_now  = 1'b0;
      weight_reg = imufp_pkg::WEIGHT_RESET;
      frames_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[2] == imufp_pkg::REG_WEIGHT) begin
        if (cfg_pwrite) weight_reg = cfg_pwdata[8:0];
        else if (cfg_prdata !== {23'b0, weight_reg})
          flag($sformatf("weight readback: expected %0d, got %0d", weight_reg, cfg_prdata));
      end
      // results first, so a frame completed at this edge is never matched early
      if (out_tvalid && out_tready) begin
        if (frames_due.size() == 0) begin
          flag("result item with no frame outstanding");
        end else begin
          want = frames_due.pop_front();
          if (out_tuser !== want.kind)
            flag($sformatf("frame_kind: expected %0d, got %0d", want.kind, out_tuser));
          if (out_tdata[15:0] !== want.raw_z)
            flag($sformatf("raw_z: expected %0d, got %0d",
                           want.raw_z, $signed(out_tdata[15:0])));
          if (out_tdata[39:16] !== want.yaw)
            flag($sformatf("yaw_filtered: expected %0d, got %0d",
                           want.yaw, $signed(out_tdata[39:16])));
          if (out_tdata[55:40] !== want.rate)
            flag($sformatf("rate_sixteenths: expected %0d, got %0d",
                           want.rate, $signed(out_tdata[55:40])));
          if (out_tdata[56] !== want.blink)
            flag($sformatf("blink: expected %0d, got %0d", want.blink, out_tdata[56]));
        end
      end
      if (in_tvalid && in_tready) take_rx_byte(in_tdata);
    end
    frames_pending = frames_due.size();
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// byte-stream regression of the imu frame parser with yaw filter: directed
// frames, then mostly well-formed random frames mixed with noise and broken
// frames, under several filter weights and back-pressure patterns
// ----------------------------------------------------------------------------
module tb_top;

  localparam int         CYCLE_LIMIT  = 200000;
  // byte address of the weight register, and one past the register map
  localparam logic [2:0] WEIGHT_ADDR  = {imufp_pkg::REG_WEIGHT, 2'b00};
  localparam logic [2:0] UNUSED_ADDR  = 3'd4;
  localparam int         PHASE_BYTES  = 200;

  typedef enum {CLEAN, BAD_SUM, BAD_HEAD, BAD_KIND, CUT_SHORT} frame_flaw_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;    // [15:0] raw_z, [39:16] yaw_filtered,
                             // [55:40] rate_sixteenths, [56] blink
  logic        out_tuser;    // [0] frame_kind
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int frames_pending;
  int cycle_count;
  int bytes_sent;
  int tx_idle_pct;
  int rx_idle_pct;

  imu_frame_parser_yaw_filter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  imufp_frame_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .mismatches     (mismatches),
    .frames_pending (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("imu_frame_parser_yaw_filter regression: fail");
      $finish;
    end
  end

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // one item on the byte channel, with random idle cycles in front of it
  task automatic send_byte(input logic [7:0] b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // register access: setup phase, then access phase until pready
  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // builds one frame of the given kind and z, spoils it as asked, sends it
  task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] z,
                            input frame_flaw_t flaw);
    logic [7:0] f [imufp_pkg::FRAME_BYTES];
    int         keep;
    keep = imufp_pkg::FRAME_BYTES;
    f[0] = imufp_pkg::HEAD_BYTE;
    f[1] = kind_byte;
    for (int i = 2; i < imufp_pkg::FRAME_BYTES - 1; i++) f[i] = 8'($urandom);
    f[6] = z[7:0];
    f[7] = z[15:8];
    f[imufp_pkg::FRAME_BYTES-1] = '0;
    for (int i = 0; i < imufp_pkg::FRAME_BYTES - 1; i++)
      f[imufp_pkg::FRAME_BYTES-1] += f[i];
    case (flaw)
      BAD_SUM:   f[imufp_pkg::FRAME_BYTES-1] ^= 8'($urandom_range(255, 1));
      BAD_HEAD: begin
        f[0] = 8'($urandom);
        if (f[0] == imufp_pkg::HEAD_BYTE) f[0] ^= 8'h01;
      end
      BAD_KIND: begin
        f[1] = 8'($urandom);
        if (f[1] == imufp_pkg::KIND_ANGLE || f[1] == imufp_pkg::KIND_RATE) f[1] ^= 8'h10;
      end
      CUT_SHORT: keep = $urandom_range(imufp_pkg::FRAME_BYTES - 1, 1);
      default: ;
    endcase
    for (int i = 0; i < keep; i++) send_byte(f[i]);
  endtask

  // the block is idle once every frame is out and the pipe has drained
  task automatic wait_idle();
    while (frames_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one random phase: new weight, new pressure pattern, then a byte budget
  task automatic run_phase(input int tx_pct, input int rx_pct, input logic [8:0] w);
    int          pick;
    int          target;
    logic [15:0] z;
    logic [7:0]  kind_byte;
    wait_idle();
    reg_access(1'b1, WEIGHT_ADDR, {23'b0, w});
    reg_access(1'b0, WEIGHT_ADDR, '0);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) begin
      pick      = $urandom_range(99);
      kind_byte = $urandom_range(1) ? imufp_pkg::KIND_ANGLE : imufp_pkg::KIND_RATE;
      case ($urandom_range(7))
        0:       z = 16'h8000;
        1:       z = 16'h7fff;
        2:       z = 16'h0000;
        3:       z = 16'hffff;
        default: z = 16'($urandom);
      endcase
      if (pick < 70) send_frame(kind_byte, z, CLEAN);
      else if (pick < 78) begin
        // line noise, often carrying a stray header byte
        repeat ($urandom_range(6, 1))
          send_byte($urandom_range(3) == 0 ? imufp_pkg::HEAD_BYTE : 8'($urandom));
      end
      else if (pick < 84) send_frame(kind_byte, z, BAD_SUM);
      else if (pick < 88) send_frame(kind_byte, z, BAD_HEAD);
      else if (pick < 92) send_frame(kind_byte, z, BAD_KIND);
      else send_frame(kind_byte, z, CUT_SHORT);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    // every input known from time zero
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cycle_count = 0;
    bytes_sent  = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset weight reads back; a write past the register map changes nothing
    reg_access(1'b0, WEIGHT_ADDR, '0);
    reg_access(1'b1, UNUSED_ADDR, 32'h0000_01ff);
    reg_access(1'b0, WEIGHT_ADDR, '0);

    // directed: byte extremes as noise, then the largest angle and the
    // most negative rate; the rate frame reports the held yaw and blink
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(imufp_pkg::KIND_ANGLE, 16'h7fff, CLEAN);
    send_frame(imufp_pkg::KIND_RATE, 16'h8000, CLEAN);
    in_tvalid <= 1'b0;

    // weights cover zero, full scale, above range (clamped) and random
    run_phase(38, 51, 9'd0);
    run_phase(38, 51, 9'd300);
    run_phase(51, 38, imufp_pkg::WEIGHT_ONE);
    run_phase(51, 38, 9'd1);
    run_phase(0, 0, 9'd511);
    run_phase(0, 0, 9'($urandom_range(511)));

    // drain: all frames out, then wait for anything unexpected
    while (frames_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && frames_pending == 0)
      $display("imu_frame_parser_yaw_filter regression: pass");
    else
      $display("imu_frame_parser_yaw_filter regression: fail");
    $finish;
  end

endmodule

### filelist.f
hdl/imufp_pkg.sv
hdl/imufp_window.sv
hdl/imufp_calc.sv
hdl/imu_frame_parser_yaw_filter.sv
sim/imufp_frame_checker.sv
sim/tb_top.sv
